/* hdl/lzmt_pkg.sv */
// ----------------------------------------------------------------------------
// lzmt_pkg
// Shared types and constants for the lidar zone minimum tracker: register
// indexes, zone numbering, fixed zone geometry and the configuration record.
// ----------------------------------------------------------------------------
package lzmt_pkg;

   // Field widths
   localparam int COORD_W = 16;
   localparam int DIST_W  = 16;
   localparam int CNT_OUT_W = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int NUM_ZONES = 7;

   // Fixed geometry of corner and side zones (mm)
   localparam int CORNER_BACKWARD_MM = 100;
   localparam int CORNER_LATERAL_MM  = 100;
   localparam int SIDE_LATERAL_MM    = 100;

   // Zone numbering (bit positions in the hit vector)
   localparam int ZONE_CONTACT    = 0;
   localparam int ZONE_FRONT      = 1;
   localparam int ZONE_REAR       = 2;
   localparam int ZONE_REAR_LEFT  = 3;
   localparam int ZONE_REAR_RIGHT = 4;
   localparam int ZONE_LEFT       = 5;
   localparam int ZONE_RIGHT      = 6;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IGNORE_NEAR     = 3'd0,
      CSR_CONTACT_FORWARD = 3'd1,
      CSR_CONTACT_HALF_W  = 3'd2,
      CSR_FRONT_FORWARD   = 3'd3,
      CSR_FRONT_HALF_W    = 3'd4,
      CSR_REAR_BACKWARD   = 3'd5,
      CSR_REAR_HALF_W     = 3'd6,
      CSR_SIDE_FORWARD    = 3'd7
   } csr_index_type;

   // Configuration record
   typedef struct packed {
      logic [14:0] ignore_near_mm;
      logic [15:0] contact_forward_mm;     // signed
      logic [14:0] contact_half_width_mm;
      logic [15:0] front_forward_mm;       // signed
      logic [14:0] front_half_width_mm;
      logic [14:0] rear_backward_mm;
      logic [14:0] rear_half_width_mm;
      logic [15:0] side_forward_mm;        // signed
   } cfg_type;

   // Zone membership of one point; contact lands on bit 0
   typedef struct packed {
      logic right;
      logic left;
      logic back_right;
      logic back_left;
      logic rear;
      logic front;
      logic contact;
   } zone_hit_type;

   // One registered input item
   typedef struct packed {
      logic              has_point;
      logic              point_valid;
      logic [COORD_W-1:0] x_mm;
      logic [COORD_W-1:0] y_mm;
      logic [DIST_W-1:0]  range_mm;
      logic              end_of_scan;
   } point_type;

endpackage

/* hdl/lzmt_req_if.sv */
// ----------------------------------------------------------------------------
// lzmt_req_if
// Point channel: valid/ready handshake with one lidar point as payload.
// ----------------------------------------------------------------------------
interface lzmt_req_if;
   logic        valid;
   logic        ready;
   logic        has_point;
   logic        point_valid;
   logic [15:0] x_mm;
   logic [15:0] y_mm;
   logic [15:0] range_mm;
   logic        end_of_scan;

   modport source (
      output valid, has_point, point_valid, x_mm, y_mm, range_mm, end_of_scan,
      input  ready
   );
   modport sink (
      input  valid, has_point, point_valid, x_mm, y_mm, range_mm, end_of_scan,
      output ready
   );
endinterface

/* hdl/lzmt_rsp_if.sv */
// ----------------------------------------------------------------------------
// lzmt_rsp_if
// Scan result channel: valid/ready handshake with per-scan zone minima.
// ----------------------------------------------------------------------------
interface lzmt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] contact_near_mm;
   logic [15:0] front_near_mm;
   logic [15:0] rear_near_mm;
   logic [15:0] back_left_near_mm;
   logic [15:0] back_right_near_mm;
   logic [15:0] left_near_mm;
   logic [15:0] right_near_mm;
   logic [15:0] prior_left_min_mm;
   logic [15:0] prior_right_min_mm;
   logic [9:0]  valid_points;
   logic [9:0]  scan_points;
   logic        scan_seen;

   modport source (
      output valid, contact_near_mm, front_near_mm, rear_near_mm, back_left_near_mm,
             back_right_near_mm, left_near_mm, right_near_mm, prior_left_min_mm,
             prior_right_min_mm, valid_points, scan_points, scan_seen,
      input  ready
   );
   modport sink (
      input  valid, contact_near_mm, front_near_mm, rear_near_mm, back_left_near_mm,
             back_right_near_mm, left_near_mm, right_near_mm, prior_left_min_mm,
             prior_right_min_mm, valid_points, scan_points, scan_seen,
      output ready
   );
endinterface

/* hdl/lzmt_zone_classify.sv */
// ----------------------------------------------------------------------------
// lzmt_zone_classify
// Combinational zone test of one point against the configured and fixed
// zone boundaries. Front wins over rear, rear-left over rear-right and
// left over right; contact is independent.
// ----------------------------------------------------------------------------
module lzmt_zone_classify (
   input  lzmt_pkg::cfg_type      cfg,
   input  logic [15:0]            x_mm,
   input  logic [15:0]            y_mm,
   output lzmt_pkg::zone_hit_type hits
);
   import lzmt_pkg::*;

   // Comparisons run at 18 bits so that |y| and negated limits never wrap
   localparam logic signed [17:0] CORNER_X_MAX = -$signed(18'(CORNER_BACKWARD_MM));
   localparam logic signed [17:0] CORNER_Y_MIN = $signed(18'(CORNER_LATERAL_MM));
   localparam logic signed [17:0] CORNER_Y_MAX = -$signed(18'(CORNER_LATERAL_MM));
   localparam logic signed [17:0] SIDE_Y_MIN   = $signed(18'(SIDE_LATERAL_MM));
   localparam logic signed [17:0] SIDE_Y_MAX   = -$signed(18'(SIDE_LATERAL_MM));

   logic signed [17:0] xs;
   logic signed [17:0] ys;
   logic signed [17:0] ay;
   logic signed [17:0] contact_x;
   logic signed [17:0] front_x;
   logic signed [17:0] side_x;
   logic signed [17:0] rear_x;
   logic signed [17:0] contact_hw;
   logic signed [17:0] front_hw;
   logic signed [17:0] rear_hw;
   logic               corner_x_ok;
   logic               side_x_ok;

   // Sign-extend coordinates and limits
   assign xs         = $signed({{2{x_mm[15]}}, x_mm});
   assign ys         = $signed({{2{y_mm[15]}}, y_mm});
   assign ay         = y_mm[15] ? -ys : ys;
   assign contact_x  = $signed({{2{cfg.contact_forward_mm[15]}}, cfg.contact_forward_mm});
   assign front_x    = $signed({{2{cfg.front_forward_mm[15]}}, cfg.front_forward_mm});
   assign side_x     = $signed({{2{cfg.side_forward_mm[15]}}, cfg.side_forward_mm});
   assign rear_x     = -$signed({3'b000, cfg.rear_backward_mm});
   assign contact_hw = $signed({3'b000, cfg.contact_half_width_mm});
   assign front_hw   = $signed({3'b000, cfg.front_half_width_mm});
   assign rear_hw    = $signed({3'b000, cfg.rear_half_width_mm});

   assign corner_x_ok = (xs <= CORNER_X_MAX);
   assign side_x_ok   = (xs >= side_x);

   // Zone membership with priorities
   always_comb begin
      hits.contact    = (xs >= contact_x) && (ay <= contact_hw);
      hits.front      = (xs >= front_x) && (ay <= front_hw);
      hits.rear       = !hits.front && (xs <= rear_x) && (ay <= rear_hw);
      hits.back_left  = corner_x_ok && (ys >= CORNER_Y_MIN);
      hits.back_right = !hits.back_left && corner_x_ok && (ys <= CORNER_Y_MAX);
      hits.left       = side_x_ok && (ys >= SIDE_Y_MIN);
      hits.right      = !hits.left && side_x_ok && (ys <= SIDE_Y_MAX);
   end

endmodule

/* hdl/lidar_zone_minimum_tracker_core.sv */
// ----------------------------------------------------------------------------
// lidar_zone_minimum_tracker_core
// Sorts a stream of lidar points into seven zones, keeps the nearest
// non-zero distance per zone and reports one result per scan.
// ----------------------------------------------------------------------------
// Takes one point per clock. A transfer on req_chan lands in an input
// register; the next cycle classifies it, updates the seven zone minima and
// the two saturating counters, and on the end-of-scan item loads the result
// register and clears the scan state. rsp_chan is driven straight from the
// result register. The only stall comes from the result
// register: an end-of-scan item waits in the input register while an earlier
// result has not been taken, and req_chan.ready drops for that time. Points
// that do not end a scan never wait on rsp_chan. Configuration writes take
// effect on the next cycle and are meant to happen while no item is in flight.
// ----------------------------------------------------------------------------
module lidar_zone_minimum_tracker_core #(
   parameter int MAX_SCAN_POINTS = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [lzmt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lzmt_pkg::CSR_DATA_W-1:0] csr_wr_data,
   lzmt_req_if.sink                       req_chan,
   lzmt_rsp_if.source                     rsp_chan
);
   import lzmt_pkg::*;

   localparam int CNT_W = $clog2(MAX_SCAN_POINTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SCAN_POINTS);

   // Configuration
   cfg_type cfg_ff;

   // Input stage
   logic      in_valid_ff;
   point_type in_ff;
   logic      accept;
   logic      fire;

   // Scan state
   logic [DIST_W-1:0] zone_min_ff  [NUM_ZONES];
   logic [DIST_W-1:0] zone_min_in  [NUM_ZONES];
   logic [DIST_W-1:0] last_left_ff;
   logic [DIST_W-1:0] last_right_ff;
   logic [CNT_W-1:0]  valid_cnt_ff;
   logic [CNT_W-1:0]  valid_cnt_in;
   logic [CNT_W-1:0]  point_cnt_ff;
   logic [CNT_W-1:0]  point_cnt_in;

   // Result stage
   logic                  rsp_valid_ff;
   logic [DIST_W-1:0]     rsp_min_ff [NUM_ZONES];
   logic [DIST_W-1:0]     rsp_prior_left_ff;
   logic [DIST_W-1:0]     rsp_prior_right_ff;
   logic [CNT_OUT_W-1:0]  rsp_valid_pts_ff;
   logic [CNT_OUT_W-1:0]  rsp_scan_pts_ff;
   logic                  rsp_have_ff;
   logic                  out_free;

   // Point processing
   zone_hit_type           hits;
   logic [NUM_ZONES-1:0]   hit_vec;
   logic                   use_point;
   logic [CNT_W+CNT_OUT_W-1:0] valid_cnt_ext;
   logic [CNT_W+CNT_OUT_W-1:0] point_cnt_ext;

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ignore_near_mm        <= 15'd50;
         cfg_ff.contact_forward_mm    <= 16'd0;
         cfg_ff.contact_half_width_mm <= 15'd150;
         cfg_ff.front_forward_mm      <= 16'd0;
         cfg_ff.front_half_width_mm   <= 15'd200;
         cfg_ff.rear_backward_mm      <= 15'd0;
         cfg_ff.rear_half_width_mm    <= 15'd200;
         cfg_ff.side_forward_mm       <= 16'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IGNORE_NEAR:     cfg_ff.ignore_near_mm        <= csr_wr_data[14:0];
            CSR_CONTACT_FORWARD: cfg_ff.contact_forward_mm    <= csr_wr_data;
            CSR_CONTACT_HALF_W:  cfg_ff.contact_half_width_mm <= csr_wr_data[14:0];
            CSR_FRONT_FORWARD:   cfg_ff.front_forward_mm      <= csr_wr_data;
            CSR_FRONT_HALF_W:    cfg_ff.front_half_width_mm   <= csr_wr_data[14:0];
            CSR_REAR_BACKWARD:   cfg_ff.rear_backward_mm      <= csr_wr_data[14:0];
            CSR_REAR_HALF_W:     cfg_ff.rear_half_width_mm    <= csr_wr_data[14:0];
            CSR_SIDE_FORWARD:    cfg_ff.side_forward_mm       <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Handshake: an end-of-scan item needs a free result register
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && (!in_ff.end_of_scan || out_free);
   assign req_chan.ready = !in_valid_ff || fire;
   assign accept         = req_chan.valid && req_chan.ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff.has_point   <= req_chan.has_point;
         in_ff.point_valid <= req_chan.point_valid;
         in_ff.x_mm        <= req_chan.x_mm;
         in_ff.y_mm        <= req_chan.y_mm;
         in_ff.range_mm    <= req_chan.range_mm;
         in_ff.end_of_scan <= req_chan.end_of_scan;
      end
   end

   // Zone classification
   lzmt_zone_classify u_classify (
      .cfg  (cfg_ff),
      .x_mm (in_ff.x_mm),
      .y_mm (in_ff.y_mm),
      .hits (hits)
   );

   assign hit_vec   = hits;
   assign use_point = in_ff.has_point && in_ff.point_valid &&
                      (in_ff.range_mm >= {1'b0, cfg_ff.ignore_near_mm}) &&
                      (in_ff.range_mm != '0);

   // Running minima and saturating counts including the current point
   always_comb begin
      for (int z = 0; z < NUM_ZONES; z++) begin
         zone_min_in[z] = zone_min_ff[z];
         if (use_point && hit_vec[z] &&
             ((zone_min_ff[z] == '0) || (in_ff.range_mm < zone_min_ff[z]))) begin
            zone_min_in[z] = in_ff.range_mm;
         end
      end
      point_cnt_in = point_cnt_ff;
      valid_cnt_in = valid_cnt_ff;
      if (in_ff.has_point) begin
         if (point_cnt_ff < CNT_MAX) begin
            point_cnt_in = point_cnt_ff + 1'b1;
         end
         if (in_ff.point_valid && (valid_cnt_ff < CNT_MAX)) begin
            valid_cnt_in = valid_cnt_ff + 1'b1;
         end
      end
   end

   assign valid_cnt_ext = (CNT_W + CNT_OUT_W)'(valid_cnt_in);
   assign point_cnt_ext = (CNT_W + CNT_OUT_W)'(point_cnt_in);

   // Scan state: accumulate, clear after the end-of-scan item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < NUM_ZONES; z++) begin
            zone_min_ff[z] <= '0;
         end
         last_left_ff  <= '0;
         last_right_ff <= '0;
         valid_cnt_ff  <= '0;
         point_cnt_ff  <= '0;
      end else if (fire) begin
         if (in_ff.end_of_scan) begin
            for (int z = 0; z < NUM_ZONES; z++) begin
               zone_min_ff[z] <= '0;
            end
            last_left_ff  <= zone_min_in[ZONE_LEFT];
            last_right_ff <= zone_min_in[ZONE_RIGHT];
            valid_cnt_ff  <= '0;
            point_cnt_ff  <= '0;
         end else begin
            for (int z = 0; z < NUM_ZONES; z++) begin
               zone_min_ff[z] <= zone_min_in[z];
            end
            valid_cnt_ff <= valid_cnt_in;
            point_cnt_ff <= point_cnt_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && in_ff.end_of_scan) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && in_ff.end_of_scan) begin
         for (int z = 0; z < NUM_ZONES; z++) begin
            rsp_min_ff[z] <= zone_min_in[z];
         end
         rsp_prior_left_ff  <= last_left_ff;
         rsp_prior_right_ff <= last_right_ff;
         rsp_valid_pts_ff   <= valid_cnt_ext[CNT_OUT_W-1:0];
         rsp_scan_pts_ff    <= point_cnt_ext[CNT_OUT_W-1:0];
         rsp_have_ff        <= (valid_cnt_in != '0);
      end
   end

   // Result channel
   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.contact_near_mm    = rsp_min_ff[ZONE_CONTACT];
   assign rsp_chan.front_near_mm      = rsp_min_ff[ZONE_FRONT];
   assign rsp_chan.rear_near_mm       = rsp_min_ff[ZONE_REAR];
   assign rsp_chan.back_left_near_mm  = rsp_min_ff[ZONE_REAR_LEFT];
   assign rsp_chan.back_right_near_mm = rsp_min_ff[ZONE_REAR_RIGHT];
   assign rsp_chan.left_near_mm       = rsp_min_ff[ZONE_LEFT];
   assign rsp_chan.right_near_mm      = rsp_min_ff[ZONE_RIGHT];
   assign rsp_chan.prior_left_min_mm  = rsp_prior_left_ff;
   assign rsp_chan.prior_right_min_mm = rsp_prior_right_ff;
   assign rsp_chan.valid_points       = rsp_valid_pts_ff;
   assign rsp_chan.scan_points        = rsp_scan_pts_ff;
   assign rsp_chan.scan_seen          = rsp_have_ff;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lidar zone minimum tracker: a directed table of
// points, then random scans under a range of register settings, with every
// scan result compared field by field against an in-bench zone tracker or a hand-written expectation.
// ----------------------------------------------------------------------------
module tb;
   import lzmt_pkg::*;

   localparam int MAX_POINTS   = 512;
   localparam int PHASE_ITEMS  = 40;
   localparam int SAT_SCAN_LEN = 530;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 4;
   localparam int TIMEOUT_NS   = 1_000_000;

   // One scan result as it appears on the result channel
   typedef struct packed {
      logic [15:0] contact_near_mm;
      logic [15:0] front_near_mm;
      logic [15:0] rear_near_mm;
      logic [15:0] back_left_near_mm;
      logic [15:0] back_right_near_mm;
      logic [15:0] left_near_mm;
      logic [15:0] right_near_mm;
      logic [15:0] prior_left_min_mm;
      logic [15:0] prior_right_min_mm;
      logic [9:0]  valid_points;
      logic [9:0]  scan_points;
      logic        scan_seen;
   } scan_summary_type;

   typedef enum {
      SET_RESET_VALUES,
      SET_NEAR_RANDOM,
      SET_LOW_LIMITS,
      SET_HIGH_LIMITS,
      SET_WIDE_OPEN,
      SET_FULL_RANDOM
   } setting_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   lzmt_req_if req_chan ();
   lzmt_rsp_if rsp_chan ();

   lidar_zone_minimum_tracker_core #(
      .MAX_SCAN_POINTS(MAX_POINTS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // Tracker copy of the registers
   logic [14:0]        cfg_ignore_near;
   logic signed [15:0] cfg_contact_fwd;
   logic [14:0]        cfg_contact_hw;
   logic signed [15:0] cfg_front_fwd;
   logic [14:0]        cfg_front_hw;
   logic [14:0]        cfg_rear_back;
   logic [14:0]        cfg_rear_hw;
   logic signed [15:0] cfg_side_fwd;

   // Tracker scan state
   logic [15:0] zone_min [NUM_ZONES];
   logic [15:0] prev_left_min;
   logic [15:0] prev_right_min;
   int          valid_count;
   int          all_count;

   scan_summary_type pending_scan_results[$];

   int mismatch_count = 0;
   int scans_checked  = 0;
   int points_sent    = 0;
   int hold_requests  = 0;
   int burst_left     = 0;
   bit no_gaps        = 0;

   setting_kind_type plan [10] = '{SET_RESET_VALUES, SET_NEAR_RANDOM, SET_LOW_LIMITS,
                                   SET_NEAR_RANDOM, SET_HIGH_LIMITS, SET_WIDE_OPEN,
                                   SET_NEAR_RANDOM, SET_FULL_RANDOM, SET_NEAR_RANDOM,
                                   SET_WIDE_OPEN};

   // Clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Zero means empty; a zero distance never lands in a zone
   function automatic void lower_min(int zone, logic [15:0] range_val);
      if (range_val != 0 && (zone_min[zone] == 0 || range_val < zone_min[zone]))
         zone_min[zone] = range_val;
   endfunction

   // Classify one point; returns 1 on end of scan with the summary filled in
   function automatic bit track_point(input point_type p, output scan_summary_type summary);
      int x, y, ay;
      int contact_hw, front_hw, rear_lim, rear_hw;
      x          = $signed(p.x_mm);
      y          = $signed(p.y_mm);
      ay         = (y < 0) ? -y : y;
      contact_hw = cfg_contact_hw;
      front_hw   = cfg_front_hw;
      rear_lim   = cfg_rear_back;
      rear_hw    = cfg_rear_hw;
      summary    = '0;
      if (p.has_point) begin
         if (all_count < MAX_POINTS) all_count++;
         if (p.point_valid && valid_count < MAX_POINTS) valid_count++;
         if (p.point_valid && p.range_mm >= cfg_ignore_near) begin
            if (x >= cfg_contact_fwd && ay <= contact_hw)
               lower_min(ZONE_CONTACT, p.range_mm);
            // rear only counts when the point missed the front zone
            if (x >= cfg_front_fwd && ay <= front_hw)
               lower_min(ZONE_FRONT, p.range_mm);
            else if (x <= -rear_lim && ay <= rear_hw)
               lower_min(ZONE_REAR, p.range_mm);
            if (x <= -CORNER_BACKWARD_MM && y >= CORNER_LATERAL_MM)
               lower_min(ZONE_REAR_LEFT, p.range_mm);
            else if (x <= -CORNER_BACKWARD_MM && y <= -CORNER_LATERAL_MM)
               lower_min(ZONE_REAR_RIGHT, p.range_mm);
            if (x >= cfg_side_fwd && y >= SIDE_LATERAL_MM)
               lower_min(ZONE_LEFT, p.range_mm);
            else if (x >= cfg_side_fwd && y <= -SIDE_LATERAL_MM)
               lower_min(ZONE_RIGHT, p.range_mm);
         end
      end
      if (!p.end_of_scan) return 1'b0;
      summary.contact_near_mm    = zone_min[ZONE_CONTACT];
      summary.front_near_mm      = zone_min[ZONE_FRONT];
      summary.rear_near_mm       = zone_min[ZONE_REAR];
      summary.back_left_near_mm  = zone_min[ZONE_REAR_LEFT];
      summary.back_right_near_mm = zone_min[ZONE_REAR_RIGHT];
      summary.left_near_mm       = zone_min[ZONE_LEFT];
      summary.right_near_mm      = zone_min[ZONE_RIGHT];
      summary.prior_left_min_mm  = prev_left_min;
      summary.prior_right_min_mm = prev_right_min;
      summary.valid_points       = valid_count[9:0];
      summary.scan_points        = all_count[9:0];
      summary.scan_seen          = (valid_count != 0);
      prev_left_min  = zone_min[ZONE_LEFT];
      prev_right_min = zone_min[ZONE_RIGHT];
      foreach (zone_min[z]) zone_min[z] = '0;
      valid_count = 0;
      all_count   = 0;
      return 1'b1;
   endfunction

   function automatic void note_point(point_type p);
      scan_summary_type summary;
      if (track_point(p, summary)) pending_scan_results.push_back(summary);
   endfunction

   function automatic point_type mk(bit has, bit ok, int x, int y, int range_val, bit eos);
      point_type p;
      p.has_point   = has;
      p.point_valid = ok;
      p.x_mm        = 16'(x);
      p.y_mm        = 16'(y);
      p.range_mm    = 16'(range_val);
      p.end_of_scan = eos;
      return p;
   endfunction

   // Coordinates mostly near the zone edges, sometimes anywhere
   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 9))
         0, 1:    return 16'($urandom);
         2:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(0, 800) - 400);
      endcase
   endfunction

   function automatic logic [15:0] pick_distance();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 16'($urandom);
         2:       return 16'(cfg_ignore_near) + 16'($urandom_range(0, 2)) - 16'd1;
         3:       return 16'hFFFF;
         default: return 16'($urandom_range(1, 3000));
      endcase
   endfunction

   function automatic point_type random_point(bit eos);
      point_type p;
      p.has_point   = ($urandom_range(0, 9) != 0);
      p.point_valid = ($urandom_range(0, 7) != 0);
      p.x_mm        = pick_coord();
      p.y_mm        = pick_coord();
      p.range_mm    = pick_distance();
      p.end_of_scan = eos;
      return p;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // One register write, mirrored into the tracker copy
   task automatic write_reg(csr_index_type idx, logic [15:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_IGNORE_NEAR:     cfg_ignore_near = data[14:0];
         CSR_CONTACT_FORWARD: cfg_contact_fwd = data;
         CSR_CONTACT_HALF_W:  cfg_contact_hw  = data[14:0];
         CSR_FRONT_FORWARD:   cfg_front_fwd   = data;
         CSR_FRONT_HALF_W:    cfg_front_hw    = data[14:0];
         CSR_REAR_BACKWARD:   cfg_rear_back   = data[14:0];
         CSR_REAR_HALF_W:     cfg_rear_hw     = data[14:0];
         CSR_SIDE_FORWARD:    cfg_side_fwd    = data;
         default: ;
      endcase
   endtask

   task automatic apply_setting(setting_kind_type kind);
      logic [15:0] v [8];
      case (kind)
         SET_RESET_VALUES: v = '{16'd50, 16'd0, 16'd150, 16'd0, 16'd200, 16'd0, 16'd200, 16'd0};
         SET_LOW_LIMITS:   v = '{16'd0, 16'h8000, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0,
                                 16'h8000};
         SET_HIGH_LIMITS:  v = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                 16'h7FFF, 16'h7FFF};
         SET_WIDE_OPEN:    v = '{16'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0,
                                 16'h7FFF, 16'h8000};
         SET_NEAR_RANDOM: begin
            v[CSR_IGNORE_NEAR]     = 16'($urandom_range(0, 200));
            v[CSR_CONTACT_FORWARD] = 16'($urandom_range(0, 600) - 300);
            v[CSR_CONTACT_HALF_W]  = 16'($urandom_range(0, 400));
            v[CSR_FRONT_FORWARD]   = 16'($urandom_range(0, 600) - 300);
            v[CSR_FRONT_HALF_W]    = 16'($urandom_range(0, 400));
            v[CSR_REAR_BACKWARD]   = 16'($urandom_range(0, 300));
            v[CSR_REAR_HALF_W]     = 16'($urandom_range(0, 400));
            v[CSR_SIDE_FORWARD]    = 16'($urandom_range(0, 600) - 300);
         end
         default: foreach (v[i]) v[i] = 16'($urandom);
      endcase
      // bit 15 of the 15-bit registers must be dropped
      foreach (v[i])
         if (i != CSR_CONTACT_FORWARD && i != CSR_FRONT_FORWARD && i != CSR_SIDE_FORWARD)
            v[i][15] = 1'($urandom_range(0, 1));
      foreach (v[i]) write_reg(csr_index_type'(i), v[i]);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Drive one point and wait for its transfer; a gap may open each new burst
   task automatic send_point(point_type p);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!no_gaps && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
      end
      burst_left--;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.has_point   <= p.has_point;
      req_chan.point_valid <= p.point_valid;
      req_chan.x_mm        <= p.x_mm;
      req_chan.y_mm        <= p.y_mm;
      req_chan.range_mm    <= p.range_mm;
      req_chan.end_of_scan <= p.end_of_scan;
      do @(posedge clock); while (!req_chan.ready);
      if (p.has_point || p.end_of_scan) points_sent++;
   endtask

   task automatic offer(point_type p);
      send_point(p);
      note_point(p);
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (pending_scan_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: own stall pattern plus a long hold-off on request
   initial begin
      logic [31:0] rx_cycle;
      int          hold_served;
      int          hold_left;
      rx_cycle       = 0;
      hold_served    = 0;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (rx_cycle[8:7])
               2'd0: rsp_chan.ready <= 1'b1;
               2'd1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2'd2: rsp_chan.ready <= (rx_cycle % 3 == 0);
               default: rsp_chan.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      scan_summary_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_scan_results.size() == 0) begin
            $error("scan result transfer with no scan pending");
            mismatch_count++;
         end else begin
            want = pending_scan_results.pop_front();
            check_field("contact_near_mm", want.contact_near_mm, rsp_chan.contact_near_mm);
            check_field("front_near_mm", want.front_near_mm, rsp_chan.front_near_mm);
            check_field("rear_near_mm", want.rear_near_mm, rsp_chan.rear_near_mm);
            check_field("back_left_near_mm", want.back_left_near_mm,
                        rsp_chan.back_left_near_mm);
            check_field("back_right_near_mm", want.back_right_near_mm,
                        rsp_chan.back_right_near_mm);
            check_field("left_near_mm", want.left_near_mm, rsp_chan.left_near_mm);
            check_field("right_near_mm", want.right_near_mm, rsp_chan.right_near_mm);
            check_field("prior_left_min_mm", want.prior_left_min_mm,
                        rsp_chan.prior_left_min_mm);
            check_field("prior_right_min_mm", want.prior_right_min_mm,
                        rsp_chan.prior_right_min_mm);
            check_field("valid_points", want.valid_points, rsp_chan.valid_points);
            check_field("scan_points", want.scan_points, rsp_chan.scan_points);
            check_field("scan_seen", want.scan_seen, rsp_chan.scan_seen);
            scans_checked++;
         end
      end
   end

   // Run limit
   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // Stimulus
   initial begin
      point_type        p;
      point_type        dir_pts[$];
      scan_summary_type dir_want[int];
      scan_summary_type summary;
      int               count, len;

      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wr_data          = '0;
      req_chan.valid       = 1'b0;
      req_chan.has_point   = 1'b0;
      req_chan.point_valid = 1'b0;
      req_chan.x_mm        = '0;
      req_chan.y_mm        = '0;
      req_chan.range_mm    = '0;
      req_chan.end_of_scan = 1'b0;

      cfg_ignore_near = 15'd50;
      cfg_contact_fwd = '0;
      cfg_contact_hw  = 15'd150;
      cfg_front_fwd   = '0;
      cfg_front_hw    = 15'd200;
      cfg_rear_back   = '0;
      cfg_rear_hw     = 15'd200;
      cfg_side_fwd    = '0;
      foreach (zone_min[z]) zone_min[z] = '0;
      prev_left_min  = '0;
      prev_right_min = '0;
      valid_count    = 0;
      all_count      = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table, reset register values
      dir_pts.push_back(mk(0, 0, 0, 0, 0, 1));                // empty marker right after reset
      dir_pts.push_back(mk(1, 1, 1000, 0, 500, 0));
      dir_pts.push_back(mk(1, 1, 0, 100, 300, 0));
      dir_pts.push_back(mk(1, 0, 0, 0, 10, 0));               // invalid, counted only
      dir_pts.push_back(mk(1, 1, 0, 0, 49, 0));               // just under the near limit
      dir_pts.push_back(mk(0, 1, -200, -200, 7777, 0));       // no point, fields ignored
      dir_pts.push_back(mk(1, 1, 32767, 32767, 65535, 0));
      dir_pts.push_back(mk(1, 1, 32767, -32768, 65535, 0));
      dir_pts.push_back(mk(1, 1, -100, 100, 1000, 0));        // rear and rear-left edges
      dir_pts.push_back(mk(1, 1, -100, -100, 900, 0));
      dir_pts.push_back(mk(1, 1, -99, 150, 800, 0));
      dir_pts.push_back(mk(1, 1, -32768, -32768, 65535, 1));  // point carried on the end item
      dir_pts.push_back(mk(0, 0, 0, 0, 0, 1));
      dir_pts.push_back(mk(1, 0, 0, 0, 100, 1));              // only an invalid point
      dir_pts.push_back(mk(1, 1, 0, -100, 65535, 0));
      dir_pts.push_back(mk(1, 1, 0, -100, 50, 0));            // exactly at the near limit
      dir_pts.push_back(mk(1, 1, -1, 200, 60, 0));
      dir_pts.push_back(mk(1, 1, -1, 201, 61, 0));
      dir_pts.push_back(mk(1, 1, 0, -32768, 1, 1));
      dir_pts.push_back(mk(0, 1, 5, 5, 5, 0));
      dir_pts.push_back(mk(1, 1, 100, 99, 123, 1));

      summary = '0;
      dir_want[0] = summary;
      summary.prior_left_min_mm  = 16'd300;
      summary.prior_right_min_mm = 16'hFFFF;
      dir_want[12] = summary;
      summary = '0;
      summary.scan_points = 10'd1;
      dir_want[13] = summary;

      foreach (dir_pts[i]) begin
         send_point(dir_pts[i]);
         if (dir_want.exists(i)) begin
            void'(track_point(dir_pts[i], summary));
            pending_scan_results.push_back(dir_want[i]);
         end else begin
            note_point(dir_pts[i]);
         end
      end
      wait_for_results();

      // Random scans, one register setting per phase
      foreach (plan[ph]) begin
         apply_setting(plan[ph]);
         no_gaps = (ph == 8);
         if (ph == 8) hold_requests <= hold_requests + 1;

         // one scan long enough to saturate both counters
         if (ph == 5) begin
            for (int k = 0; k < SAT_SCAN_LEN; k++) begin
               p = random_point(k == SAT_SCAN_LEN - 1);
               p.has_point = 1'b1;
               if (k < 520) p.point_valid = 1'b1;
               offer(p);
            end
         end

         count = 0;
         while (count < PHASE_ITEMS) begin
            len = no_gaps ? $urandom_range(0, 2) : $urandom_range(0, 15);
            for (int k = 0; k < len; k++) begin
               p = random_point(1'b0);
               offer(p);
               if (p.has_point) count++;
            end
            offer(random_point(1'b1));
            count++;
         end

         // sometimes leave points open across the register change
         if ($urandom_range(0, 1) != 0) begin
            repeat ($urandom_range(1, 3)) begin
               p = random_point(1'b0);
               p.has_point = 1'b1;
               offer(p);
            end
         end
         wait_for_results();
      end

      if (pending_scan_results.size() != 0) begin
         $error("%0d scan results never arrived", pending_scan_results.size());
         mismatch_count++;
      end
      $display("Checked %0d scan results from %0d points over %0d register settings,",
               scans_checked, points_sent, $size(plan) + 1);
      $display("including count saturation and a %0d-cycle result stall.", HOLD_CYCLES);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
